// ===== hdl/krt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the record table with undo stack.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int Capacity = 32;
   localparam int IdxW     = $clog2(Capacity);
   localparam int CntW     = $clog2(Capacity + 1);

   typedef enum logic [2:0] {
      FN_ADD     = 3'd0,
      FN_DELETE  = 3'd1,
      FN_UNDO    = 3'd2,
      FN_SORT    = 3'd3,
      FN_SEARCH  = 3'd4,
      FN_DISPLAY = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_UNDO_EMPTY = 3'd4,
      ST_BLOCKED   = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   localparam logic [1:0] KEY_GRADE = 2'd0;
   localparam logic [1:0] KEY_ID    = 2'd1;
   localparam logic [1:0] KEY_NAME  = 2'd2;

   typedef struct packed {
      logic [31:0] id;
      logic [63:0] name;
      logic [15:0] grade;
   } rec_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] rec_id;
      logic [63:0]        rec_name;
      logic [15:0]        rec_grade;
      logic [1:0]         sort_key;
      logic               ascending;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               has_record;
      logic signed [31:0] out_id;
      logic [63:0]        out_name;
      logic [15:0]        out_grade;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_W,
      S_SHIFT,
      S_SHIFT_W,
      S_UNDO_RD,
      S_UNDO_W,
      S_SORT_RD,
      S_SORT_W,
      S_SORT_CMP,
      S_DISP,
      S_DISP_W,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/krt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_ram
// Single-port synchronous record memory with registered read.
// ----------------------------------------------------------------------------
module krt_ram
   import krt_pkg::*;
#(
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire rec_type                  wr_data,
   output rec_type                       rd_data
);

   rec_type mem [Depth];

   // write, and registered read that returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
`default_nettype wire

// ===== hdl/keyed_record_table_undo_sort_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table_undo_sort_core
// Ordered record table with an undo stack, held in two single-port memories.
// ----------------------------------------------------------------------------
// One request at a time. Most operations walk the table memory, one read or
// write per cycle with a registered read: search and duplicate checks read
// each scanned entry and then compare it, add/undo shift the table down by
// reading and writing each record, delete shifts up after the scan, display
// reads one record per result and waits for each result to be taken. Sort is
// an insertion sort that holds the record being placed in a register and moves
// entries that belong after it down. An undo reads the top of the undo stack
// before the scan. No clearing pass after reset.
module keyed_record_table_undo_sort_core
   import krt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CntW-1:0] count_ff, count_in, depth_ff, depth_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;
   rec_type   hold_ff, hold_in;
   logic [2:0] goal_ff, goal_in;
   rsp_type   rsp_ff, rsp_in;
   logic      found_ff, found_in;
   logic [CntW-1:0] pos_ff, pos_in;

   logic    t_we, u_we;
   logic [IdxW-1:0] t_addr, u_addr;
   rec_type t_wd, u_wd, t_rd, u_rd;

   krt_ram #(.Depth(Capacity)) u_table (
      .clock(clock), .wr_en(t_we), .addr(t_addr), .wr_data(t_wd), .rd_data(t_rd));
   krt_ram #(.Depth(Capacity)) u_undo (
      .clock(clock), .wr_en(u_we), .addr(u_addr), .wr_data(u_wd), .rd_data(u_rd));

   // goal codes after a scan
   localparam logic [2:0] G_ADD = 3'd0, G_DEL = 3'd1, G_SRCH = 3'd2, G_UNDO = 3'd3;

   // compare: does stored record a belong after hold (moves down)?
   function automatic logic after_hold(rec_type a, rec_type h, logic [1:0] k, logic asc);
      logic gt, lt;
      gt = 1'b0;
      lt = 1'b0;
      case (k)
         KEY_GRADE: begin gt = a.grade > h.grade; lt = a.grade < h.grade; end
         KEY_ID: begin
            gt = $signed(a.id) > $signed(h.id);
            lt = $signed(a.id) < $signed(h.id);
         end
         default: begin gt = a.name > h.name; lt = a.name < h.name; end
      endcase
      return asc ? gt : lt;
   endfunction

   function automatic rsp_type mk(status_type s, logic h, rec_type r, logic l);
      rsp_type o;
      o.status     = s;
      o.has_record = h;
      o.out_id     = h ? r.id : '0;
      o.out_name   = h ? r.name : '0;
      o.out_grade  = h ? r.grade : '0;
      o.last       = l;
      return o;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         depth_ff <= depth_in;
      end
      req_ff   <= req_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      hold_ff  <= hold_in;
      goal_ff  <= goal_in;
      rsp_ff   <= rsp_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   // next state and memory control
   always_comb begin
      rec_type nr;
      state_in = state_ff;
      req_in   = req_ff;
      count_in = count_ff;
      depth_in = depth_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      hold_in  = hold_ff;
      goal_in  = goal_ff;
      rsp_in   = rsp_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      t_we = 1'b0; t_addr = i_ff[IdxW-1:0]; t_wd = hold_ff;
      u_we = 1'b0; u_addr = '0; u_wd = hold_ff;
      nr.id = req_ff.rec_id; nr.name = req_ff.rec_name; nr.grade = req_ff.rec_grade;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               i_in     = '0;
               found_in = 1'b0;
               hold_in.id = req_data.rec_id;
               hold_in.name = req_data.rec_name;
               hold_in.grade = req_data.rec_grade;
               unique case (req_data.func)
                  FN_ADD:    begin goal_in = G_ADD;  state_in = S_SCAN; end
                  FN_DELETE: begin goal_in = G_DEL;  state_in = S_SCAN; end
                  FN_SEARCH: begin goal_in = G_SRCH; state_in = S_SCAN; end
                  FN_UNDO: begin
                     if (depth_ff == '0) begin
                        rsp_in = mk(ST_UNDO_EMPTY, 1'b0, hold_in, 1'b1);
                        state_in = S_OUT;
                     end else if (count_ff >= CntW'(Capacity)) begin
                        rsp_in = mk(ST_FULL, 1'b0, hold_in, 1'b1);
                        state_in = S_OUT;
                     end else begin
                        state_in = S_UNDO_RD;
                     end
                  end
                  FN_SORT: begin
                     i_in = CntW'(1);
                     rsp_in = mk(ST_OK, 1'b0, hold_in, 1'b1);
                     if (req_data.sort_key > KEY_NAME || count_ff < CntW'(2))
                        state_in = S_OUT;
                     else
                        state_in = S_SORT_RD;
                  end
                  FN_DISPLAY: begin
                     if (count_ff == '0) begin
                        rsp_in = mk(ST_EMPTY, 1'b0, hold_in, 1'b1);
                        state_in = S_OUT;
                     end else begin
                        state_in = S_DISP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // undo: read top of stack
         S_UNDO_RD: begin
            u_addr = IdxW'(depth_ff - CntW'(1));
            depth_in = depth_ff - CntW'(1);
            goal_in = G_UNDO;
            state_in = S_UNDO_W;
         end
         S_UNDO_W: begin
            hold_in = u_rd;
            i_in = '0;
            found_in = 1'b0;
            state_in = S_SCAN;
         end
         // linear scan for hold id
         S_SCAN: begin
            if (i_ff >= count_ff) begin
               unique case (goal_ff)
                  G_ADD: begin
                     if (count_ff >= CntW'(Capacity)) begin
                        rsp_in = mk(ST_FULL, 1'b0, nr, 1'b1);
                        state_in = S_OUT;
                     end else begin
                        rsp_in = mk(ST_OK, 1'b0, nr, 1'b1);
                        i_in = count_ff;
                        state_in = S_SHIFT;
                     end
                  end
                  G_UNDO: begin
                     rsp_in = mk(ST_OK, 1'b1, hold_ff, 1'b1);
                     i_in = count_ff;
                     state_in = S_SHIFT;
                  end
                  default: begin
                     rsp_in = mk(ST_NOT_FOUND, 1'b0, nr, 1'b1);
                     state_in = S_OUT;
                  end
               endcase
            end else begin
               t_addr = i_ff[IdxW-1:0];
               state_in = S_SCAN_W;
            end
         end
         S_SCAN_W: begin
            if (t_rd.id == hold_ff.id) begin
               unique case (goal_ff)
                  G_ADD: begin
                     rsp_in = mk(ST_DUPLICATE, 1'b0, nr, 1'b1);
                     state_in = S_OUT;
                  end
                  G_UNDO: begin
                     rsp_in = mk(ST_BLOCKED, 1'b1, hold_ff, 1'b1);
                     state_in = S_OUT;
                  end
                  G_SRCH: begin
                     rsp_in = mk(ST_OK, 1'b1, t_rd, 1'b1);
                     state_in = S_OUT;
                  end
                  default: begin
                     // delete: push onto undo stack if it has room, then close the gap
                     rsp_in = mk(ST_OK, 1'b1, t_rd, 1'b1);
                     if (depth_ff < CntW'(Capacity)) begin
                        u_we = 1'b1;
                        u_addr = depth_ff[IdxW-1:0];
                        u_wd = t_rd;
                        depth_in = depth_ff + CntW'(1);
                     end
                     found_in = 1'b1;
                     i_in = i_ff + CntW'(1);
                     state_in = S_SHIFT;
                  end
               endcase
            end else begin
               i_in = i_ff + CntW'(1);
               state_in = S_SCAN;
            end
         end
         // shift: insert at front moves down (i counts down); delete moves up
         S_SHIFT: begin
            if (found_ff) begin
               if (i_ff >= count_ff) begin
                  count_in = count_ff - CntW'(1);
                  state_in = S_OUT;
               end else begin
                  t_addr = i_ff[IdxW-1:0];
                  state_in = S_SHIFT_W;
               end
            end else if (i_ff == '0) begin
               t_we = 1'b1;
               t_addr = '0;
               t_wd = (goal_ff == G_ADD) ? nr : hold_ff;
               count_in = count_ff + CntW'(1);
               state_in = S_OUT;
            end else begin
               t_addr = IdxW'(i_ff - CntW'(1));
               state_in = S_SHIFT_W;
            end
         end
         S_SHIFT_W: begin
            t_we = 1'b1;
            t_wd = t_rd;
            if (found_ff) begin
               t_addr = IdxW'(i_ff - CntW'(1));
               i_in = i_ff + CntW'(1);
            end else begin
               t_addr = i_ff[IdxW-1:0];
               i_in = i_ff - CntW'(1);
            end
            state_in = S_SHIFT;
         end
         // insertion sort: i is the element being placed, j the hole
         S_SORT_RD: begin
            if (i_ff >= count_ff) begin
               state_in = S_OUT;
            end else begin
               t_addr = i_ff[IdxW-1:0];
               j_in = i_ff;
               state_in = S_SORT_W;
            end
         end
         S_SORT_W: begin
            if (j_ff == i_ff) hold_in = t_rd;
            t_addr = IdxW'(j_ff - CntW'(1));
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if (after_hold(t_rd, hold_ff, req_ff.sort_key, req_ff.ascending)) begin
               t_we = 1'b1;
               t_addr = j_ff[IdxW-1:0];
               t_wd = t_rd;
               j_in = j_ff - CntW'(1);
               if (j_ff == CntW'(1)) begin
                  state_in = S_SORT_CMP;
                  pos_in = '0;
                  found_in = 1'b1;
               end else begin
                  state_in = S_SORT_W;
               end
            end else begin
               found_in = 1'b1;
               pos_in = j_ff;
            end
            if (found_ff) begin
               // hold goes into the hole
               t_we = 1'b1;
               t_addr = pos_ff[IdxW-1:0];
               t_wd = hold_ff;
               found_in = 1'b0;
               i_in = i_ff + CntW'(1);
               state_in = S_SORT_RD;
            end else if (!after_hold(t_rd, hold_ff, req_ff.sort_key, req_ff.ascending)) begin
               state_in = S_SORT_CMP;
            end
         end
         // display walk
         S_DISP: begin
            t_addr = i_ff[IdxW-1:0];
            state_in = S_DISP_W;
         end
         S_DISP_W: begin
            rsp_in = mk(ST_OK, 1'b1, t_rd, (i_ff + CntW'(1)) == count_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (req_ff.func == FN_DISPLAY && !rsp_ff.last && count_ff != '0) begin
                  i_in = i_ff + CntW'(1);
                  state_in = S_DISP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== tb/keyed_record_table_undo_sort_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_undo_sort_core_test
// Checks the record table with undo stack: a directed table of requests and
// then random request sequences. Every result is compared against a
// behavioral table model kept in the bench, with random gaps on both channels.
// ----------------------------------------------------------------------------
module keyed_record_table_undo_sort_core_test;
   import krt_pkg::*;

   localparam int NumRandom = 136;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   keyed_record_table_undo_sort_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // model state
   rec_type   tbl [Capacity];
   int        tbl_count;
   rec_type   stack [Capacity];
   int        stack_depth;
   rsp_type   pending_rsp [$];
   int        errors;
   bit        req_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic rsp_type make_rsp(status_type st, bit has, rec_type r, bit fin);
      rsp_type o;
      o.status     = st;
      o.has_record = has;
      o.out_id     = has ? r.id : '0;
      o.out_name   = has ? r.name : '0;
      o.out_grade  = has ? r.grade : '0;
      o.last       = fin;
      return o;
   endfunction

   function automatic int find_rec(logic [31:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl[i].id == id) return i;
      return -1;
   endfunction

   function automatic void insert_front(rec_type r);
      for (int i = tbl_count; i > 0; i--) tbl[i] = tbl[i-1];
      tbl[0] = r;
      tbl_count++;
   endfunction

   // -1, 0, 1 compare of two table entries under a sort key
   function automatic int order_of(rec_type a, rec_type b, logic [1:0] key);
      logic [63:0] x, y;
      if (key == KEY_GRADE) begin
         x = 64'(a.grade); y = 64'(b.grade);
      end else if (key == KEY_ID) begin
         x = 64'(a.id ^ 32'h8000_0000); y = 64'(b.id ^ 32'h8000_0000);
      end else begin
         x = a.name; y = b.name;
      end
      return (x > y) ? 1 : ((x < y) ? -1 : 0);
   endfunction

   // apply one request to the model and queue its results
   function automatic void predict_table(req_type q);
      rec_type r, z;
      int      pos, c, j;
      z = '0;
      r.id = q.rec_id; r.name = q.rec_name; r.grade = q.rec_grade;
      case (q.func)
         FN_ADD: begin
            if (find_rec(q.rec_id) >= 0)
               pending_rsp.push_back(make_rsp(ST_DUPLICATE, 0, z, 1));
            else if (tbl_count >= Capacity)
               pending_rsp.push_back(make_rsp(ST_FULL, 0, z, 1));
            else begin
               insert_front(r);
               pending_rsp.push_back(make_rsp(ST_OK, 0, z, 1));
            end
         end
         FN_DELETE: begin
            pos = find_rec(q.rec_id);
            if (pos < 0)
               pending_rsp.push_back(make_rsp(ST_NOT_FOUND, 0, z, 1));
            else begin
               r = tbl[pos];
               for (int i = pos; i + 1 < tbl_count; i++) tbl[i] = tbl[i+1];
               tbl_count--;
               if (stack_depth < Capacity) begin
                  stack[stack_depth] = r;
                  stack_depth++;
               end
               pending_rsp.push_back(make_rsp(ST_OK, 1, r, 1));
            end
         end
         FN_UNDO: begin
            if (stack_depth == 0)
               pending_rsp.push_back(make_rsp(ST_UNDO_EMPTY, 0, z, 1));
            else if (tbl_count >= Capacity)
               pending_rsp.push_back(make_rsp(ST_FULL, 0, z, 1));
            else begin
               stack_depth--;
               r = stack[stack_depth];
               if (find_rec(r.id) >= 0)
                  pending_rsp.push_back(make_rsp(ST_BLOCKED, 1, r, 1));
               else begin
                  insert_front(r);
                  pending_rsp.push_back(make_rsp(ST_OK, 1, r, 1));
               end
            end
         end
         FN_SORT: begin
            if (q.sort_key <= KEY_NAME && tbl_count >= 2)
               for (int i = 1; i < tbl_count; i++) begin
                  j = i;
                  while (j > 0) begin
                     c = order_of(tbl[j-1], tbl[j], q.sort_key);
                     if (!(q.ascending ? c > 0 : c < 0)) break;
                     r = tbl[j]; tbl[j] = tbl[j-1]; tbl[j-1] = r;
                     j--;
                  end
               end
            pending_rsp.push_back(make_rsp(ST_OK, 0, z, 1));
         end
         FN_SEARCH: begin
            pos = find_rec(q.rec_id);
            if (pos < 0) pending_rsp.push_back(make_rsp(ST_NOT_FOUND, 0, z, 1));
            else pending_rsp.push_back(make_rsp(ST_OK, 1, tbl[pos], 1));
         end
         FN_DISPLAY: begin
            if (tbl_count == 0) pending_rsp.push_back(make_rsp(ST_EMPTY, 0, z, 1));
            else
               for (int i = 0; i < tbl_count; i++)
                  pending_rsp.push_back(make_rsp(ST_OK, 1, tbl[i], i + 1 == tbl_count));
         end
         default: ;
      endcase
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type make_req(logic [2:0] f, logic [31:0] id, logic [63:0] nm,
                                        logic [15:0] gr, logic [1:0] key, bit asc);
      req_type q;
      q.func = f; q.rec_id = id; q.rec_name = nm; q.rec_grade = gr;
      q.sort_key = key; q.ascending = asc;
      return q;
   endfunction

   // send one request, predicting at acceptance; valid drops only over a gap
   task automatic send_request(req_type q);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table(q);
      @(negedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_data.status); errors++;
            end
            if (rsp_data.has_record !== exp_rsp.has_record) begin
               $error("has_record exp %0d got %0d", exp_rsp.has_record,
                      rsp_data.has_record); errors++;
            end
            if (rsp_data.out_id !== exp_rsp.out_id) begin
               $error("out_id exp %0d got %0d", exp_rsp.out_id, rsp_data.out_id); errors++;
            end
            if (rsp_data.out_name !== exp_rsp.out_name) begin
               $error("out_name exp %h got %h", exp_rsp.out_name, rsp_data.out_name);
               errors++;
            end
            if (rsp_data.out_grade !== exp_rsp.out_grade) begin
               $error("out_grade exp %0d got %0d", exp_rsp.out_grade, rsp_data.out_grade);
               errors++;
            end
            if (rsp_data.last !== exp_rsp.last) begin
               $error("last exp %0d got %0d", exp_rsp.last, rsp_data.last); errors++;
            end
         end
      end
   end

   // result-side stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 40) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(5, 25)) @(negedge clock);
         end else if (req_done) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 9) < 7) ||
                         ($urandom_range(0, 2) == 0);
         end
      end
   end

   // directed rows: request plus an optional typed expectation of status
   typedef struct {
      req_type    q;
      bit         fixed;
      status_type st;
   } row_type;

   initial begin
      row_type     rows [$];
      logic [31:0] id;
      int          wait_cnt, kind;
      req_type     q;

      errors = 0; req_done = 0;
      tbl_count = 0; stack_depth = 0;
      req_valid = 1'b0;
      req_data  = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      rows.push_back('{make_req(FN_DISPLAY, 0, 0, 0, 0, 0), 1, ST_EMPTY});
      rows.push_back('{make_req(FN_UNDO, 0, 0, 0, 0, 0), 1, ST_UNDO_EMPTY});
      rows.push_back('{make_req(FN_DELETE, 5, 0, 0, 0, 0), 1, ST_NOT_FOUND});
      rows.push_back('{make_req(FN_SEARCH, 5, 0, 0, 0, 0), 1, ST_NOT_FOUND});
      rows.push_back('{make_req(FN_SORT, 0, 0, 0, KEY_ID, 1), 1, ST_OK});
      rows.push_back('{make_req(FN_ADD, 32'h8000_0000, '1, 16'hFFFF, 0, 0), 1, ST_OK});
      rows.push_back('{make_req(FN_ADD, 32'h7FFF_FFFF, 0, 0, 0, 0), 1, ST_OK});
      rows.push_back('{make_req(FN_ADD, 32'h8000_0000, 1, 1, 0, 0), 1, ST_DUPLICATE});
      rows.push_back('{make_req(FN_ADD, 0, 64'h4142_4300_0000_0000, 500, 3, 1), 1, ST_OK});
      rows.push_back('{make_req(FN_ADD, -1, 64'h4100_0000_0000_0000, 500, 0, 0), 1, ST_OK});
      rows.push_back('{make_req(FN_DISPLAY, 0, 0, 0, 0, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_SORT, 0, 0, 0, KEY_GRADE, 1), 0, ST_OK});
      rows.push_back('{make_req(FN_SORT, 0, 0, 0, KEY_ID, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_SORT, 0, 0, 0, KEY_NAME, 1), 0, ST_OK});
      rows.push_back('{make_req(FN_SORT, 0, 0, 0, 2'd3, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_DISPLAY, 0, 0, 0, 0, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_SEARCH, -1, 0, 0, 0, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_DELETE, 0, 0, 0, 0, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_ADD, 0, 7, 7, 0, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_UNDO, 0, 0, 0, 0, 0), 1, ST_BLOCKED});
      rows.push_back('{make_req(3'd6, 0, 0, 0, 0, 0), 0, ST_OK});
      rows.push_back('{make_req(3'd7, 9, 0, 0, 0, 0), 0, ST_OK});
      rows.push_back('{make_req(FN_DISPLAY, 0, 0, 0, 0, 0), 0, ST_OK});
      foreach (rows[i]) begin
         send_request(rows[i].q);
         if (rows[i].fixed && pending_rsp.size() > 0 &&
             pending_rsp[$].status != rows[i].st) begin
            $error("status exp %0d got %0d", rows[i].st, pending_rsp[$].status);
            errors++;
         end
      end

      // fill past capacity, full-table cases, then delete every record to fill the undo stack and go past full
      for (int i = 0; i < Capacity + 1; i++)
         send_request(make_req(FN_ADD, 1000 + i, {$urandom, $urandom}, 16'($urandom),
                               0, 0));
      send_request(make_req(FN_UNDO, 0, 0, 0, 0, 0));
      send_request(make_req(FN_SORT, 0, 0, 0, KEY_NAME, 0));
      send_request(make_req(FN_DISPLAY, 0, 0, 0, 0, 0));
      for (int i = 0; i < Capacity; i++)
         send_request(make_req(FN_DELETE, tbl[$urandom_range(0, tbl_count-1)].id, 0, 0,
                               0, 0));
      send_request(make_req(FN_ADD, 1, 1, 1, 0, 0));
      send_request(make_req(FN_DELETE, 1, 0, 0, 0, 0));
      send_request(make_req(FN_UNDO, 0, 0, 0, 0, 0));

      // random part, mostly ids from a small pool so hits are common
      for (int n = 0; n < NumRandom; n++) begin
         kind = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0) id = $urandom;
         else id = $urandom_range(0, 40) - 20;
         if (tbl_count > 0 && $urandom_range(0, 1))
            id = tbl[$urandom_range(0, tbl_count - 1)].id;
         if (kind < 35)      q = make_req(FN_ADD, id, 0, 0, 0, 0);
         else if (kind < 50) q = make_req(FN_DELETE, id, 0, 0, 0, 0);
         else if (kind < 62) q = make_req(FN_UNDO, id, 0, 0, 0, 0);
         else if (kind < 74) q = make_req(FN_SORT, id, 0, 0, 0, 0);
         else if (kind < 86) q = make_req(FN_SEARCH, id, 0, 0, 0, 0);
         else if (kind < 97) q = make_req(FN_DISPLAY, id, 0, 0, 0, 0);
         else                q = make_req(3'(6 + $urandom_range(0, 1)), id, 0, 0, 0, 0);
         q.rec_name  = {$urandom, $urandom};
         if ($urandom_range(0, 2) == 0) q.rec_name[31:0] = '0;
         q.rec_grade = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20));
         q.sort_key  = 2'($urandom);
         q.ascending = 1'($urandom);
         send_request(q);
      end
      req_valid <= 1'b0;
      req_done = 1;

      // drain
      wait_cnt = 0;
      while (pending_rsp.size() > 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (2000) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/krt_pkg.sv
hdl/krt_ram.sv
hdl/keyed_record_table_undo_sort_core.sv
tb/keyed_record_table_undo_sort_core_test.sv
